### design/lru_pr_pkg.sv
// ---------------------------------------------------------------------------
// lru_pr_pkg: shared types and constants of the LRU page replacement core
// Field widths of the request, response and control channels, and the
// sequencer state type.
// ---------------------------------------------------------------------------
package lru_pr_pkg;

   localparam int PAGE_ID_W  = 16;
   localparam int SLOT_OUT_W = 3;
   localparam int FAULT_W    = 16;
   localparam int CFG_W      = 4;

   localparam logic [CFG_W-1:0]   FRAMES_RESET = 4'd8;
   localparam logic [FAULT_W-1:0] FAULT_MAX    = 16'hFFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DECIDE,
      ST_UPDATE,
      ST_RESPOND
   } state_type;

endpackage

### design/lru_pr_channels.sv
// ---------------------------------------------------------------------------
// lru_pr_channels: valid/ready channels of the LRU page replacement core
// Request channel, response channel and the control register write channel.
// ---------------------------------------------------------------------------
interface lru_pr_req_if;
   logic                             valid;
   logic                             ready;
   logic [lru_pr_pkg::PAGE_ID_W-1:0] page_id;
   logic                             last_reference;

   modport source (output valid, output page_id, output last_reference, input ready);
   modport sink (input valid, input page_id, input last_reference, output ready);
endinterface

interface lru_pr_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              hit;
   logic [lru_pr_pkg::SLOT_OUT_W-1:0] frame_slot;
   logic                              evicted_valid;
   logic [lru_pr_pkg::PAGE_ID_W-1:0]  evicted_page;
   logic [lru_pr_pkg::FAULT_W-1:0]    fault_total;

   modport source (output valid, output hit, output frame_slot, output evicted_valid,
                   output evicted_page, output fault_total, input ready);
   modport sink (input valid, input hit, input frame_slot, input evicted_valid,
                 input evicted_page, input fault_total, output ready);
endinterface

interface lru_pr_csr_if;
   logic                         valid;
   logic                         ready;
   logic [lru_pr_pkg::CFG_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### design/lru_pr_ram.sv
// ---------------------------------------------------------------------------
// lru_pr_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the address.
// ---------------------------------------------------------------------------
module lru_pr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8,
   localparam int AddrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AddrBits-1:0] wr_addr,
   input  logic [WIDTH-1:0]    wr_data,
   input  logic [AddrBits-1:0] rd_addr,
   output logic [WIDTH-1:0]    rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/lru_page_replacement_core.sv
// ---------------------------------------------------------------------------
// lru_page_replacement_core: LRU page replacement unit
// Flow: a request is taken only in idle; a search pass, a decide step and an update
//   pass follow, both passes walking the memories one frame per cycle over the
//   filled frames; the response is registered; a held response stalls the next request.
// Reset: clears the fill count and the fault count and sets the frame limit to 8.
// ---------------------------------------------------------------------------
module lru_page_replacement_core #(
   parameter int NUM_FRAMES = 8,
   parameter int PAGE_BITS  = 16
) (
   input logic          clock,
   input logic          reset,
   lru_pr_req_if.sink   req_port,
   lru_pr_rsp_if.source rsp_port,
   lru_pr_csr_if.sink   csr_port
);

   localparam int SlotBits  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int CntBits   = $clog2(NUM_FRAMES + 1);
   localparam int StoreBits = (PAGE_BITS < lru_pr_pkg::PAGE_ID_W) ? PAGE_BITS
                                                                  : lru_pr_pkg::PAGE_ID_W;

   lru_pr_pkg::state_type state_ff, state_in;

   logic [lru_pr_pkg::CFG_W-1:0]   frames_ff, frames_in;
   logic [CntBits-1:0]             filled_ff, filled_in;
   logic [lru_pr_pkg::FAULT_W-1:0] fault_ff, fault_in;
   logic [CntBits-1:0]             rd_idx_ff, rd_idx_in;
   logic                           pv_ff, pv_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   logic [SlotBits-1:0]  pidx_ff, pidx_in;
   logic [StoreBits-1:0] page_ff, page_in;
   logic                 last_ff, last_in;
   logic                 hit_found_ff, hit_found_in;
   logic [SlotBits-1:0]  hit_slot_ff, hit_slot_in;
   logic [SlotBits-1:0]  hit_rank_ff, hit_rank_in;
   logic                 max_found_ff, max_found_in;
   logic [SlotBits-1:0]  max_slot_ff, max_slot_in;
   logic [SlotBits-1:0]  max_rank_ff, max_rank_in;
   logic [StoreBits-1:0] max_page_ff, max_page_in;
   logic [SlotBits-1:0]  tgt_slot_ff, tgt_slot_in;
   logic [SlotBits-1:0]  tgt_rank_ff, tgt_rank_in;
   logic                 do_hit_ff, do_hit_in;
   logic                 do_fill_ff, do_fill_in;

   logic                              o_hit_ff, o_hit_in;
   logic [lru_pr_pkg::SLOT_OUT_W-1:0] o_slot_ff, o_slot_in;
   logic                              o_ev_valid_ff, o_ev_valid_in;
   logic [lru_pr_pkg::PAGE_ID_W-1:0]  o_ev_page_ff, o_ev_page_in;
   logic [lru_pr_pkg::FAULT_W-1:0]    o_fault_ff, o_fault_in;

   logic                 pg_wr_en;
   logic [SlotBits-1:0]  pg_wr_addr;
   logic [StoreBits-1:0] pg_wr_data;
   logic [StoreBits-1:0] pg_rd_data;
   logic                 rk_wr_en;
   logic [SlotBits-1:0]  rk_wr_addr;
   logic [SlotBits-1:0]  rk_wr_data;
   logic [SlotBits-1:0]  rk_rd_data;
   logic [SlotBits-1:0]  rd_addr;

   logic [7:0] slot_wide;
   logic [7:0] cfg_wide;
   logic [7:0] limit_wide;
   logic [7:0] filled_wide;
   logic       fill_ok;

   lru_pr_ram #(
      .WIDTH (StoreBits),
      .DEPTH (NUM_FRAMES)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (pg_wr_en),
      .wr_addr (pg_wr_addr),
      .wr_data (pg_wr_data),
      .rd_addr (rd_addr),
      .rd_data (pg_rd_data)
   );

   lru_pr_ram #(
      .WIDTH (SlotBits),
      .DEPTH (NUM_FRAMES)
   ) u_rank_ram (
      .clock   (clock),
      .wr_en   (rk_wr_en),
      .wr_addr (rk_wr_addr),
      .wr_data (rk_wr_data),
      .rd_addr (rd_addr),
      .rd_data (rk_rd_data)
   );

   // Frames fill in slot order, so slot i is valid exactly when i < filled_ff.
   assign slot_wide   = 8'(tgt_slot_ff);
   assign cfg_wide    = 8'(frames_ff);
   assign filled_wide = 8'(filled_ff);
   assign limit_wide  = (cfg_wide == 8'd0) ? 8'd1 :
                        (cfg_wide > 8'(NUM_FRAMES)) ? 8'(NUM_FRAMES) : cfg_wide;
   assign fill_ok     = filled_wide < limit_wide;

   assign rd_addr        = rd_idx_ff[SlotBits-1:0];
   assign req_port.ready = (state_ff == lru_pr_pkg::ST_IDLE);
   assign csr_port.ready = 1'b1;

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.hit           = o_hit_ff;
   assign rsp_port.frame_slot    = o_slot_ff;
   assign rsp_port.evicted_valid = o_ev_valid_ff;
   assign rsp_port.evicted_page  = o_ev_page_ff;
   assign rsp_port.fault_total   = o_fault_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lru_pr_pkg::ST_IDLE: begin
            if (req_port.valid) begin
               state_in = lru_pr_pkg::ST_SEARCH;
            end
         end
         lru_pr_pkg::ST_SEARCH: begin
            if (rd_idx_ff == filled_ff && !pv_ff) begin
               state_in = lru_pr_pkg::ST_DECIDE;
            end
         end
         lru_pr_pkg::ST_DECIDE: begin
            state_in = lru_pr_pkg::ST_UPDATE;
         end
         lru_pr_pkg::ST_UPDATE: begin
            if (rd_idx_ff == filled_ff && !pv_ff) begin
               state_in = lru_pr_pkg::ST_RESPOND;
            end
         end
         lru_pr_pkg::ST_RESPOND: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               state_in = lru_pr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lru_pr_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      frames_in     = frames_ff;
      filled_in     = filled_ff;
      fault_in      = fault_ff;
      rd_idx_in     = rd_idx_ff;
      pv_in         = 1'b0;
      pidx_in       = pidx_ff;
      page_in       = page_ff;
      last_in       = last_ff;
      hit_found_in  = hit_found_ff;
      hit_slot_in   = hit_slot_ff;
      hit_rank_in   = hit_rank_ff;
      max_found_in  = max_found_ff;
      max_slot_in   = max_slot_ff;
      max_rank_in   = max_rank_ff;
      max_page_in   = max_page_ff;
      tgt_slot_in   = tgt_slot_ff;
      tgt_rank_in   = tgt_rank_ff;
      do_hit_in     = do_hit_ff;
      do_fill_in    = do_fill_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;
      o_hit_in      = o_hit_ff;
      o_slot_in     = o_slot_ff;
      o_ev_valid_in = o_ev_valid_ff;
      o_ev_page_in  = o_ev_page_ff;
      o_fault_in    = o_fault_ff;
      pg_wr_en      = 1'b0;
      pg_wr_addr    = tgt_slot_ff;
      pg_wr_data    = page_ff;
      rk_wr_en      = 1'b0;
      rk_wr_addr    = pidx_ff;
      rk_wr_data    = '0;

      if (csr_port.valid) begin
         frames_in = csr_port.data;
      end

      unique case (state_ff)
         lru_pr_pkg::ST_IDLE: begin
            if (req_port.valid) begin
               page_in      = req_port.page_id[StoreBits-1:0];
               last_in      = req_port.last_reference;
               rd_idx_in    = '0;
               hit_found_in = 1'b0;
               max_found_in = 1'b0;
            end
         end
         lru_pr_pkg::ST_SEARCH: begin
            if (rd_idx_ff != filled_ff) begin
               pv_in     = 1'b1;
               pidx_in   = rd_idx_ff[SlotBits-1:0];
               rd_idx_in = rd_idx_ff + CntBits'(1);
            end
            // Read data of the previous cycle's frame: first match wins, and
            // the lowest slot with the highest rank is the eviction choice.
            if (pv_ff) begin
               if (!hit_found_ff && pg_rd_data == page_ff) begin
                  hit_found_in = 1'b1;
                  hit_slot_in  = pidx_ff;
                  hit_rank_in  = rk_rd_data;
               end
               if (!max_found_ff || rk_rd_data > max_rank_ff) begin
                  max_found_in = 1'b1;
                  max_slot_in  = pidx_ff;
                  max_rank_in  = rk_rd_data;
                  max_page_in  = pg_rd_data;
               end
            end
         end
         lru_pr_pkg::ST_DECIDE: begin
            rd_idx_in = '0;
            if (hit_found_ff) begin
               do_hit_in   = 1'b1;
               do_fill_in  = 1'b0;
               tgt_slot_in = hit_slot_ff;
               tgt_rank_in = hit_rank_ff;
            end else begin
               do_hit_in = 1'b0;
               if (fault_ff != lru_pr_pkg::FAULT_MAX) begin
                  fault_in = fault_ff + lru_pr_pkg::FAULT_W'(1);
               end
               if (fill_ok) begin
                  do_fill_in  = 1'b1;
                  tgt_slot_in = filled_ff[SlotBits-1:0];
                  tgt_rank_in = '0;
                  filled_in   = filled_ff + CntBits'(1);
               end else begin
                  do_fill_in  = 1'b0;
                  tgt_slot_in = max_slot_ff;
                  tgt_rank_in = max_rank_ff;
               end
               pg_wr_en   = 1'b1;
               pg_wr_addr = tgt_slot_in;
            end
         end
         lru_pr_pkg::ST_UPDATE: begin
            if (rd_idx_ff != filled_ff) begin
               pv_in     = 1'b1;
               pidx_in   = rd_idx_ff[SlotBits-1:0];
               rd_idx_in = rd_idx_ff + CntBits'(1);
            end
            // Rank write-back comes in the cycle after the read, always at the
            // previous slot, so a read never meets a pending write.
            if (pv_ff) begin
               rk_wr_en = 1'b1;
               if (pidx_ff == tgt_slot_ff) begin
                  rk_wr_data = '0;
               end else if (do_fill_ff || rk_rd_data < tgt_rank_ff) begin
                  rk_wr_data = rk_rd_data + SlotBits'(1);
               end else begin
                  rk_wr_data = rk_rd_data;
               end
            end
         end
         lru_pr_pkg::ST_RESPOND: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in  = 1'b1;
               o_hit_in      = do_hit_ff;
               o_slot_in     = slot_wide[lru_pr_pkg::SLOT_OUT_W-1:0];
               o_ev_valid_in = !do_hit_ff && !do_fill_ff;
               o_ev_page_in  = (!do_hit_ff && !do_fill_ff) ?
                               lru_pr_pkg::PAGE_ID_W'(max_page_ff) : '0;
               o_fault_in    = fault_ff;
               if (last_ff) begin
                  filled_in = '0;
                  fault_in  = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lru_pr_pkg::ST_IDLE;
         frames_ff    <= lru_pr_pkg::FRAMES_RESET;
         filled_ff    <= '0;
         fault_ff     <= '0;
         rd_idx_ff    <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frames_ff    <= frames_in;
         filled_ff    <= filled_in;
         fault_ff     <= fault_in;
         rd_idx_ff    <= rd_idx_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff       <= pidx_in;
      page_ff       <= page_in;
      last_ff       <= last_in;
      hit_found_ff  <= hit_found_in;
      hit_slot_ff   <= hit_slot_in;
      hit_rank_ff   <= hit_rank_in;
      max_found_ff  <= max_found_in;
      max_slot_ff   <= max_slot_in;
      max_rank_ff   <= max_rank_in;
      max_page_ff   <= max_page_in;
      tgt_slot_ff   <= tgt_slot_in;
      tgt_rank_ff   <= tgt_rank_in;
      do_hit_ff     <= do_hit_in;
      do_fill_ff    <= do_fill_in;
      o_hit_ff      <= o_hit_in;
      o_slot_ff     <= o_slot_in;
      o_ev_valid_ff <= o_ev_valid_in;
      o_ev_page_ff  <= o_ev_page_in;
      o_fault_ff    <= o_fault_in;
   end

endmodule

### tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// testbench: self-checking bench for lru_page_replacement_core
// Reference strings with random locality are sent through the request
// channel. A local LRU predictor computes each response, and the monitor
// checks every response beat field by field. Runs cover several frame
// limits, including out-of-range values and limits lowered in mid-string.
// Runs also cover sender and receiver idling and a long receiver hold.
// ---------------------------------------------------------------------------
module testbench;

   localparam int FRAME_COUNT = 8;
   localparam int HOLD_CYCLES = 400;
   localparam int PAGE_W      = lru_pr_pkg::PAGE_ID_W;

   typedef struct packed {
      logic                              hit;
      logic [lru_pr_pkg::SLOT_OUT_W-1:0] slot;
      logic                              evicted;
      logic [PAGE_W-1:0]                 evicted_page;
      logic [lru_pr_pkg::FAULT_W-1:0]    faults;
   } page_outcome_type;

   typedef struct packed {
      logic [PAGE_W-1:0] page;
      logic              last;
   } page_ref_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lru_pr_req_if req_chan ();
   lru_pr_rsp_if rsp_chan ();
   lru_pr_csr_if csr_chan ();

   lru_page_replacement_core #(
      .NUM_FRAMES(FRAME_COUNT),
      .PAGE_BITS (PAGE_W)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_port(req_chan),
      .rsp_port(rsp_chan),
      .csr_port(csr_chan)
   );

   always #5 clock = ~clock;

   // Predictor state: a private copy of the frame table.
   logic [lru_pr_pkg::CFG_W-1:0]   frames_cfg = lru_pr_pkg::FRAMES_RESET;
   logic [PAGE_W-1:0]              held_page [FRAME_COUNT];
   bit                             held_valid [FRAME_COUNT];
   int                             held_rank [FRAME_COUNT];
   int                             filled_count;
   logic [lru_pr_pkg::FAULT_W-1:0] fault_count;

   page_ref_type     reference_queue [$];
   page_outcome_type expected_outcomes [$];
   page_ref_type     next_ref;

   int  sender_idle_pct = 0;
   int  rsp_stall_pct   = 0;
   bit  rx_hold         = 1'b0;
   int  mismatch_count  = 0;
   int  refs_accepted   = 0;
   int  hits_seen       = 0;
   int  evictions_seen  = 0;
   int  settings_used   = 0;

   function automatic void drop_frames();
      for (int i = 0; i < FRAME_COUNT; i++) begin
         held_valid[i] = 1'b0;
         held_rank[i]  = 0;
      end
      filled_count = 0;
      fault_count  = '0;
   endfunction

   // Make slot s the most recent; every valid slot younger than it ages by one.
   function automatic void promote_slot(int s);
      int old_rank;
      old_rank = held_rank[s];
      for (int i = 0; i < FRAME_COUNT; i++)
         if (held_valid[i] && i != s && held_rank[i] < old_rank)
            held_rank[i]++;
      held_rank[s] = 0;
   endfunction

   function automatic page_outcome_type resolve_reference(logic [PAGE_W-1:0] page,
                                                          logic last);
      page_outcome_type r;
      int               limit;
      int               slot;
      int               best;
      bit               found;
      r     = '0;
      limit = int'(frames_cfg);
      if (limit < 1) limit = 1;
      if (limit > FRAME_COUNT) limit = FRAME_COUNT;
      found = 1'b0;
      slot  = 0;
      for (int i = 0; i < FRAME_COUNT; i++) begin
         if (!found && held_valid[i] && held_page[i] == page) begin
            found = 1'b1;
            slot  = i;
         end
      end
      if (found) begin
         r.hit = 1'b1;
         promote_slot(slot);
      end else begin
         if (filled_count < limit) begin
            slot = filled_count;
            for (int i = 0; i < FRAME_COUNT; i++)
               if (held_valid[i]) held_rank[i]++;
            held_valid[slot] = 1'b1;
            held_rank[slot]  = 0;
            filled_count++;
         end else begin
            // A lowered limit still evicts among all valid frames; ties go to the
            // lowest slot.
            best = -1;
            for (int i = 0; i < FRAME_COUNT; i++) begin
               if (held_valid[i] && held_rank[i] > best) begin
                  best = held_rank[i];
                  slot = i;
               end
            end
            r.evicted      = 1'b1;
            r.evicted_page = held_page[slot];
            promote_slot(slot);
         end
         held_page[slot] = page;
         if (fault_count != lru_pr_pkg::FAULT_MAX) fault_count++;
      end
      r.slot   = slot[lru_pr_pkg::SLOT_OUT_W-1:0];
      r.faults = fault_count;
      if (last) drop_frames();
      return r;
   endfunction

   task automatic report_mismatch(string field, int unsigned want, int unsigned got);
      mismatch_count++;
      $display("Mismatch on response beat %0d: %s expected %0h, got %0h",
               refs_accepted, field, want, got);
   endtask

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_outcomes.insert(expected_outcomes.size(),
                                     resolve_reference(req_chan.page_id,
                                                       req_chan.last_reference));
            refs_accepted++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (reference_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               next_ref                = reference_queue.pop_front();
               req_chan.valid          <= 1'b1;
               req_chan.page_id        <= next_ref.page;
               req_chan.last_reference <= next_ref.last;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Response receiver.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= !rx_hold && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      page_outcome_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_outcomes.size() == 0) begin
            report_mismatch("beat with no request outstanding", 0, 1);
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_chan.hit !== want.hit)
               report_mismatch("hit", want.hit, rsp_chan.hit);
            if (rsp_chan.frame_slot !== want.slot)
               report_mismatch("frame_slot", want.slot, rsp_chan.frame_slot);
            if (rsp_chan.evicted_valid !== want.evicted)
               report_mismatch("evicted_valid", want.evicted, rsp_chan.evicted_valid);
            if (rsp_chan.evicted_page !== want.evicted_page)
               report_mismatch("evicted_page", want.evicted_page, rsp_chan.evicted_page);
            if (rsp_chan.fault_total !== want.faults)
               report_mismatch("fault_total", want.faults, rsp_chan.fault_total);
            if (want.hit) hits_seen++;
            if (want.evicted) evictions_seen++;
         end
      end
   end

   task automatic push_ref(logic [PAGE_W-1:0] page, logic last);
      page_ref_type r;
      r.page = page;
      r.last = last;
      reference_queue.insert(reference_queue.size(), r);
   endtask

   task automatic wait_drained();
      while (reference_queue.size() != 0 || req_chan.valid || expected_outcomes.size() != 0)
         @(negedge clock);
   endtask

   // The receiver hold runs as its own process and counts its own cycles.
   task automatic hold_receiver(int cycles);
      rx_hold = 1'b1;
      repeat (cycles) @(negedge clock);
      rx_hold = 1'b0;
   endtask

   task automatic write_frame_limit(logic [lru_pr_pkg::CFG_W-1:0] value);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      frames_cfg = value;
      settings_used++;
      csr_chan.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_idle_profile(int profile);
      case (profile)
         1: begin sender_idle_pct = 67; rsp_stall_pct = 0;  end
         2: begin sender_idle_pct = 0;  rsp_stall_pct = 67; end
         3: begin sender_idle_pct = 11; rsp_stall_pct = 11; end
         default: begin sender_idle_pct = 0; rsp_stall_pct = 0; end
      endcase
   endtask

   // A reference string over a small working set, so that hits and evictions
   // both happen. A few stray pages and early end markers act as noise.
   task automatic queue_reference_string(int count, bit close);
      logic [PAGE_W-1:0] working [16];
      int                ws;
      int                pick;
      logic [PAGE_W-1:0] page;
      logic              last;
      ws = $urandom_range(12, 1);
      for (int i = 0; i < ws; i++) begin
         pick = $urandom_range(9);
         if (pick == 0) working[i] = '0;
         else if (pick == 1) working[i] = '1;
         else working[i] = PAGE_W'($urandom_range(65535));
      end
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(99) < 80) page = working[$urandom_range(ws - 1)];
         else page = PAGE_W'($urandom_range(65535));
         last = (close && k == count - 1) || ($urandom_range(99) < 2);
         push_ref(page, last);
      end
   endtask

   initial begin
      logic [lru_pr_pkg::CFG_W-1:0] limit_plan [8];
      int                           budget;
      int                           len;
      limit_plan = '{4'd15, 4'd3, 4'd1, 4'd0, 4'd8, 4'd12, 4'd5, 4'd2};
      drop_frames();
      req_chan.valid          = 1'b0;
      req_chan.page_id        = '0;
      req_chan.last_reference = 1'b0;
      rsp_chan.ready          = 1'b0;
      csr_chan.valid          = 1'b0;
      csr_chan.data           = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: page zero and all-ones pages, a full fill, hits, LRU evictions
      // and the end of a string followed by a fresh one.
      push_ref(16'h0000, 1'b0);
      push_ref(16'hFFFF, 1'b0);
      push_ref(16'h0000, 1'b0);
      for (int p = 1; p <= 6; p++) push_ref(PAGE_W'(p), 1'b0);
      push_ref(16'hFFFF, 1'b0);
      push_ref(16'h0007, 1'b0);
      push_ref(16'h0000, 1'b0);
      push_ref(16'h5555, 1'b0);
      push_ref(16'hAAAA, 1'b0);
      push_ref(16'h0001, 1'b1);
      push_ref(16'h0001, 1'b0);
      push_ref(16'h0001, 1'b1);
      wait_drained();

      // Register extreme: zero acts as one frame; values above eight act as eight (random phases).
      write_frame_limit(4'd0);
      for (int i = 0; i < 6; i++) push_ref(PAGE_W'(i % 3), i == 5);
      wait_drained();

      // Random phases. Even phases leave their last string open so that the
      // next limit takes effect in mid-string, sometimes lowered.
      for (int ph = 0; ph < 8; ph++) begin
         write_frame_limit(limit_plan[ph]);
         set_idle_profile(ph % 4);
         budget = 250;
         while (budget > 0) begin
            len = $urandom_range(60, 5);
            if (len > budget) len = budget;
            budget -= len;
            queue_reference_string(len, budget > 0 || ph % 2 == 1);
            if ($urandom_range(3) == 0) wait_drained();
         end
         wait_drained();
      end

      // Long receiver hold while the sender keeps offering requests.
      write_frame_limit(4'd8);
      set_idle_profile(0);
      queue_reference_string(40, 1'b1);
      fork
         hold_receiver(HOLD_CYCLES);
      join_none
      wait_drained();

      repeat (40) @(posedge clock);
      $display("Checked %0d references: %0d hits, %0d evictions, %0d limit writes.",
               refs_accepted, hits_seen, evictions_seen, settings_used);
      $display("Covered idle and stall mixes, lowered limits and a long receiver hold.");
      if (mismatch_count == 0 && expected_outcomes.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #80_000_000;
      $display("Timeout with %0d responses outstanding", expected_outcomes.size());
      $display("FAILED: results differ");
      $finish;
   end

endmodule
